>>> hw/rtl/fhmpt_pkg.sv
package fhmpt_pkg;

   // Field and word widths.
   localparam int unsigned DataWidth  = 32;
   localparam int unsigned ProdWidth  = 64;
   localparam int unsigned CsrIdxW    = 8;
   localparam int unsigned ReqDataW   = 8;
   localparam int unsigned RspDataW   = 40;

   // Ticks spent in pause before falling back to return.
   localparam int unsigned PauseTicksDefault = 15;

   // Step time 4 ms as an unsigned Q0.32 fraction (truncated).
   localparam logic signed [DataWidth-1:0] StepQ32 = 32'sd17179869;

   // Operating modes.
   typedef enum logic [1:0] {
      MODE_RETURN = 2'd0,
      MODE_UP     = 2'd1,
      MODE_DOWN   = 2'd2,
      MODE_PAUSE  = 2'd3
   } mode_type;

   // Item kinds carried on the input user field.
   localparam logic CmdTick    = 1'b0;
   localparam logic CmdRequest = 1'b1;

   // Configuration register indexes.
   localparam logic [CsrIdxW-1:0] RegUpTarget   = 8'd0;
   localparam logic [CsrIdxW-1:0] RegDownTarget = 8'd1;
   localparam logic [CsrIdxW-1:0] RegUpKp       = 8'd2;
   localparam logic [CsrIdxW-1:0] RegUpKd       = 8'd3;
   localparam logic [CsrIdxW-1:0] RegDownKp     = 8'd4;
   localparam logic [CsrIdxW-1:0] RegDownKd     = 8'd5;
   localparam logic [CsrIdxW-1:0] RegReturnKp   = 8'd6;
   localparam logic [CsrIdxW-1:0] RegReturnKd   = 8'd7;

   // Sequencer states, one-hot.
   typedef enum logic [9:0] {
      ST_IDLE = 10'b00_0000_0001,
      ST_ERR  = 10'b00_0000_0010,
      ST_MULP = 10'b00_0000_0100,
      ST_MULD = 10'b00_0000_1000,
      ST_ACC  = 10'b00_0001_0000,
      ST_MULV = 10'b00_0010_0000,
      ST_VEL  = 10'b00_0100_0000,
      ST_MULH = 10'b00_1000_0000,
      ST_HGT  = 10'b01_0000_0000,
      ST_DONE = 10'b10_0000_0000
   } state_type;

   // Clamp a 64-bit signed value to the 32-bit signed range.
   function automatic logic signed [DataWidth-1:0] sat_from64(
      input logic signed [ProdWidth-1:0] v
   );
      logic all_zero;
      logic all_one;
      all_zero = ~|v[ProdWidth-1:DataWidth-1];
      all_one  = &v[ProdWidth-1:DataWidth-1];
      if (all_zero || all_one) begin
         return v[DataWidth-1:0];
      end else if (v[ProdWidth-1]) begin
         return {1'b1, {(DataWidth-1){1'b0}}};
      end else begin
         return {1'b0, {(DataWidth-1){1'b1}}};
      end
   endfunction

   // Clamp a 33-bit signed sum to the 32-bit signed range.
   function automatic logic signed [DataWidth-1:0] sat_from33(
      input logic signed [DataWidth:0] v
   );
      if (v[DataWidth] == v[DataWidth-1]) begin
         return v[DataWidth-1:0];
      end else if (v[DataWidth]) begin
         return {1'b1, {(DataWidth-1){1'b0}}};
      end else begin
         return {1'b0, {(DataWidth-1){1'b1}}};
      end
   endfunction

endpackage

>>> hw/rtl/foot_height_mode_pd_tracker.sv
// Channel   Direction  Handshake            Payload
// req       in         req_tvalid/tready    tuser: cmd; tdata: requested_mode
// rsp       out        rsp_tvalid/tready    tdata: height, mode_now, request_taken
// csr       in         csr_valid/csr_ready  csr_index, csr_data
//
// A control tick runs through ERR, MULP, MULD, ACC, MULV, VEL, MULH, HGT and
// DONE: one signed 33x32 multiplier is shared by the four products (P, D, velocity
// step, height step) and each product is registered before it is used.
// Reset is synchronous and clears every register but opnd, prod, p and rsp_data.
// req_tready is high only while the sequencer is idle; the result register
// holds while rsp_tready is low, and a finished item waits for it to empty.
module foot_height_mode_pd_tracker #(
   parameter int unsigned PauseTicks = fhmpt_pkg::PauseTicksDefault
) (
   input  logic                                clock,
   input  logic                                reset,
   // Input items.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic                                req_tuser,   // [0] cmd
   input  logic [fhmpt_pkg::ReqDataW-1:0]      req_tdata,   // [1:0] requested_mode
   // Result items.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [31:0] height, [33:32] mode_now, [34] request_taken, [39:35] zero
   output logic [fhmpt_pkg::RspDataW-1:0]      rsp_tdata,
   // Configuration writes.
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [fhmpt_pkg::CsrIdxW-1:0]       csr_index,
   input  logic [fhmpt_pkg::DataWidth-1:0]     csr_data
);
   import fhmpt_pkg::*;

   localparam int unsigned PauseW = $clog2(PauseTicks + 1);
   localparam logic [PauseW-1:0] PauseLoad = PauseW'(PauseTicks);

   // Configuration registers.
   logic signed [DataWidth-1:0] up_target_ff, down_target_ff;
   logic [DataWidth-1:0] up_kp_ff, up_kd_ff, down_kp_ff, down_kd_ff;
   logic [DataWidth-1:0] return_kp_ff, return_kd_ff;

   // Sequencer and dynamics state.
   state_type state_ff, state_in;
   mode_type mode_ff, mode_in;
   logic signed [DataWidth-1:0] height_ff, height_in;
   logic signed [DataWidth-1:0] vel_ff, vel_in;
   logic signed [DataWidth-1:0] target_ff, target_in;
   logic [PauseW-1:0] pause_left_ff, pause_left_in;
   logic taken_ff, taken_in;

   // Working registers of the shared multiplier path.
   logic signed [DataWidth-1:0] opnd_ff, opnd_in;
   logic signed [ProdWidth-1:0] prod_ff, prod_in;
   logic signed [ProdWidth-1:0] p_ff, p_in;

   // Result register.
   logic rsp_valid_ff, rsp_valid_in;
   logic [RspDataW-1:0] rsp_data_ff, rsp_data_in;

   // Combinational helpers.
   logic [DataWidth-1:0] kp_sel, kd_sel;
   logic is_pause;
   logic signed [DataWidth:0] mul_a;
   logic signed [DataWidth-1:0] mul_b;
   logic signed [2*DataWidth:0] mul_full;
   logic signed [DataWidth:0] err_sum, vel_sum, hgt_sum;
   logic signed [ProdWidth-1:0] d_term;
   logic [PauseW-1:0] pause_dec;
   mode_type req_mode;
   logic req_ok;
   logic out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign is_pause   = (mode_ff == MODE_PAUSE);
   assign req_mode   = mode_type'(req_tdata[1:0]);

   // Gains follow the current mode; pause runs on the down gains.
   always_comb begin
      unique case (mode_ff)
         MODE_UP: begin
            kp_sel = up_kp_ff;
            kd_sel = up_kd_ff;
         end
         MODE_DOWN, MODE_PAUSE: begin
            kp_sel = down_kp_ff;
            kd_sel = down_kd_ff;
         end
         default: begin
            kp_sel = return_kp_ff;
            kd_sel = return_kd_ff;
         end
      endcase
   end

   // Acceptance rules for a mode request.
   always_comb begin
      req_ok = 1'b0;
      if (req_mode != mode_ff) begin
         unique case (mode_ff)
            MODE_RETURN: req_ok = (req_mode == MODE_UP);
            MODE_UP:     req_ok = 1'b1;
            MODE_DOWN:   req_ok = (req_mode != MODE_UP);
            default:     req_ok = (req_mode == MODE_RETURN);
         endcase
      end
   end

   // Operand selection for the shared multiplier.
   always_comb begin
      unique case (state_ff)
         ST_MULP: begin
            mul_a = $signed({1'b0, kp_sel});
            mul_b = opnd_ff;
         end
         ST_MULD: begin
            mul_a = $signed({1'b0, kd_sel});
            mul_b = vel_ff;
         end
         ST_MULH: begin
            mul_a = {vel_ff[DataWidth-1], vel_ff};
            mul_b = StepQ32;
         end
         default: begin
            mul_a = {opnd_ff[DataWidth-1], opnd_ff};
            mul_b = StepQ32;
         end
      endcase
      mul_full = mul_a * mul_b;
   end

   // Adders and shifts around the multiplier. The upper product word is the
   // floored step and is sign-extended before the add.
   always_comb begin
      err_sum = {target_ff[DataWidth-1], target_ff} - {height_ff[DataWidth-1], height_ff};
      vel_sum = {vel_ff[DataWidth-1], vel_ff}
              + {prod_ff[ProdWidth-1], prod_ff[ProdWidth-1:DataWidth]};
      hgt_sum = {height_ff[DataWidth-1], height_ff}
              + {prod_ff[ProdWidth-1], prod_ff[ProdWidth-1:DataWidth]};
      // Pause doubles kd: shift by 15 instead of 16.
      d_term  = is_pause ? (prod_ff >>> 15) : (prod_ff >>> 16);
      pause_dec = (pause_left_ff != '0) ? pause_left_ff - PauseW'(1) : '0;
   end

   // Sequencer and datapath next state.
   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      height_in     = height_ff;
      vel_in        = vel_ff;
      target_in     = target_ff;
      pause_left_in = pause_left_ff;
      taken_in      = taken_ff;
      opnd_in       = opnd_ff;
      prod_in       = prod_ff;
      p_in          = p_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               taken_in = 1'b0;
               if (req_tuser == CmdTick) begin
                  state_in = ST_ERR;
               end else begin
                  state_in = ST_DONE;
                  if (req_ok) begin
                     taken_in = 1'b1;
                     mode_in  = req_mode;
                     unique case (req_mode)
                        MODE_UP:   target_in = up_target_ff;
                        MODE_DOWN: target_in = down_target_ff;
                        MODE_PAUSE: begin
                           target_in     = height_ff;
                           pause_left_in = PauseLoad;
                        end
                        default:   target_in = '0;
                     endcase
                  end
               end
            end
         end
         ST_ERR: begin
            opnd_in  = sat_from33(err_sum);
            state_in = ST_MULP;
         end
         ST_MULP: begin
            prod_in  = ProdWidth'(mul_full);
            state_in = ST_MULD;
         end
         ST_MULD: begin
            // Pause halves kp: one more bit of right shift.
            p_in     = is_pause ? (prod_ff >>> 17) : (prod_ff >>> 16);
            prod_in  = ProdWidth'(mul_full);
            state_in = ST_ACC;
         end
         ST_ACC: begin
            opnd_in  = sat_from64(p_ff - d_term);
            state_in = ST_MULV;
         end
         ST_MULV: begin
            prod_in  = ProdWidth'(mul_full);
            state_in = ST_VEL;
         end
         ST_VEL: begin
            vel_in   = sat_from33(vel_sum);
            state_in = ST_MULH;
         end
         ST_MULH: begin
            prod_in  = ProdWidth'(mul_full);
            state_in = ST_HGT;
         end
         ST_HGT: begin
            height_in = sat_from33(hgt_sum);
            if (is_pause) begin
               pause_left_in = pause_dec;
               if (pause_dec == '0) begin
                  mode_in   = MODE_RETURN;
                  target_in = '0;
               end
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {5'd0, taken_ff, mode_ff, height_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         mode_ff       <= MODE_RETURN;
         height_ff     <= '0;
         vel_ff        <= '0;
         target_ff     <= '0;
         pause_left_ff <= '0;
         taken_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         mode_ff       <= mode_in;
         height_ff     <= height_in;
         vel_ff        <= vel_in;
         target_ff     <= target_in;
         pause_left_ff <= pause_left_in;
         taken_ff      <= taken_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      opnd_ff     <= opnd_in;
      prod_ff     <= prod_in;
      p_ff        <= p_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Configuration register writes; unknown indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         up_target_ff   <= '0;
         down_target_ff <= '0;
         up_kp_ff       <= '0;
         up_kd_ff       <= '0;
         down_kp_ff     <= '0;
         down_kd_ff     <= '0;
         return_kp_ff   <= '0;
         return_kd_ff   <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            RegUpTarget:   up_target_ff   <= csr_data;
            RegDownTarget: down_target_ff <= csr_data;
            RegUpKp:       up_kp_ff       <= csr_data;
            RegUpKd:       up_kd_ff       <= csr_data;
            RegDownKp:     down_kp_ff     <= csr_data;
            RegDownKd:     down_kd_ff     <= csr_data;
            RegReturnKp:   return_kp_ff   <= csr_data;
            RegReturnKd:   return_kd_ff   <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // Sequencer encoding stays one-hot.
   assert property (@(posedge clock) disable iff (reset) $onehot(state_ff))
      else $error("sequencer state is not one-hot");

   // Between items, pause mode always has ticks left.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && mode_ff == MODE_PAUSE) |-> (pause_left_ff != '0))
      else $error("idle in pause with an empty pause count");

   // Mode changes only on a request transfer or at the end of a tick.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE && state_ff != ST_HGT) |=> $stable(mode_ff))
      else $error("mode changed in the middle of a tick");

   // A tick never reports a taken request.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ERR) |-> !taken_ff)
      else $error("request flag set during a tick");

   // After an input transfer the block is busy, not ready, in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("ready right after an input transfer");

endmodule
